/* design/llts_pkg.sv */
// Shared types and constants for the least-laxity task scheduler.
// Used by the controller, the datapath and the top level; depends on nothing.
package llts_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned FIELD_W = 16;
  localparam int unsigned IDX_IN_W = 3;
  localparam int unsigned MASK_W = 8;
  localparam int unsigned LAX_W = 18;
  localparam int unsigned IN_DATA_W = 72;
  localparam int unsigned OUT_DATA_W = 24;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV_D,
    ST_DIV_P,
    ST_APPLY,
    ST_FINISH
  } llts_state_t;

  typedef struct packed {
    logic load;
    logic tick_init;
    logic div_start;
    logic div_sel_p;
    logic latch_d;
    logic latch_p;
    logic apply;
    logic use_div;
    logic step;
    logic finish;
  } llts_cmd_t;

  typedef struct packed {
    logic need_div;
    logic last_idx;
    logic div_done;
    logic out_free;
  } llts_status_t;

endpackage

/* design/llts_div.sv */
// Restoring remainder unit, one quotient bit per cycle.
// Depends on llts_pkg for the field widths.
module llts_div
  import llts_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [TIME_W-1:0]  dividend,
  input  logic [FIELD_W-1:0] divisor,
  output logic               done,
  output logic [FIELD_W-1:0] remainder
);

  localparam int unsigned CNT_W = $clog2(TIME_W + 1);

  logic [TIME_W-1:0]  quo;
  logic [FIELD_W-1:0] dvs;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic [FIELD_W:0]   shifted;
  logic [FIELD_W+1:0] diff;

  assign shifted = {remainder, quo[TIME_W-1]};
  assign diff = {1'b0, shifted} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(TIME_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[TIME_W-2:0], 1'b0};
      if (diff[FIELD_W+1]) begin
        remainder <= shifted[FIELD_W-1:0];
      end else begin
        remainder <= diff[FIELD_W-1:0];
      end
    end
  end

endmodule

/* design/llts_ctrl.sv */
// Sequencer of the scheduler: loads, the per-task walk of a tick and result hand-off.
// Depends on llts_pkg for the state, command and status types.
module llts_ctrl
  import llts_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic         in_cmd,
  output logic         in_ready,
  input  llts_status_t status,
  output llts_cmd_t    cmd
);

  llts_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && in_cmd == CMD_TICK) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (status.need_div) state_next = ST_DIV_D;
        else if (status.last_idx) state_next = ST_FINISH;
      end
      ST_DIV_D: begin
        if (status.div_done) state_next = ST_DIV_P;
      end
      ST_DIV_P: begin
        if (status.div_done) state_next = ST_APPLY;
      end
      ST_APPLY: begin
        state_next = status.last_idx ? ST_FINISH : ST_EVAL;
      end
      ST_FINISH: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid && in_cmd == CMD_LOAD;
        cmd.tick_init = in_valid && in_cmd == CMD_TICK;
      end
      ST_EVAL: begin
        if (status.need_div) begin
          cmd.div_start = 1'b1;
        end else begin
          cmd.apply = 1'b1;
          cmd.step = 1'b1;
        end
      end
      ST_DIV_D: begin
        if (status.div_done) begin
          cmd.latch_d = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel_p = 1'b1;
        end
      end
      ST_DIV_P: begin
        cmd.latch_p = status.div_done;
      end
      ST_APPLY: begin
        cmd.apply = 1'b1;
        cmd.use_div = 1'b1;
        cmd.step = 1'b1;
      end
      ST_FINISH: begin
        cmd.finish = status.out_free;
      end
      default: ;
    endcase
  end

endmodule

/* design/llts_dp.sv */
// Datapath of the scheduler: task table, work left, phase trackers, selection, output register.
// Depends on llts_pkg and on the llts_div remainder unit.
module llts_dp
  import llts_pkg::*;
#(
  parameter int unsigned NUM_TASKS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  llts_cmd_t             cmd,
  output llts_status_t          status,
  input  logic [IN_DATA_W-1:0]  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_chosen,
  output logic [OUT_DATA_W-1:0] out_data
);

  localparam int unsigned IW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

  logic [FIELD_W-1:0] st_tab [NUM_TASKS];
  logic [FIELD_W-1:0] dl_tab [NUM_TASKS];
  logic [FIELD_W-1:0] rp_tab [NUM_TASKS];
  logic [FIELD_W-1:0] wr_tab [NUM_TASKS];
  logic [FIELD_W-1:0] work_left [NUM_TASKS];
  logic [FIELD_W-1:0] ph_d [NUM_TASKS];
  logic [FIELD_W-1:0] ph_p [NUM_TASKS];
  logic [NUM_TASKS-1:0] synced;

  logic [TIME_W-1:0]  time_now;
  logic [IW-1:0]      idx;
  logic               found;
  logic [IW-1:0]      best;
  logic signed [LAX_W-1:0] best_lax;
  logic [MASK_W-1:0]  missed;
  logic [MASK_W-1:0]  released;
  logic [FIELD_W-1:0] rem_d;
  logic [FIELD_W-1:0] rem_p;

  logic [IDX_IN_W-1:0] ld_idx;
  logic                ld_ok;
  logic [FIELD_W-1:0]  cur_st, cur_dl, cur_rp, cur_wr, cur_wl;
  logic [TIME_W-1:0]   x;
  logic                active;
  logic [FIELD_W:0]    inc_d, inc_p;
  logic [FIELD_W-1:0]  fast_d, fast_p, pd, pp;
  logic [FIELD_W:0]    sum_w;
  logic [FIELD_W-1:0]  wnew;
  logic                rel, miss;
  logic signed [LAX_W-1:0] lax;
  logic                cand;
  logic                in_mask;
  logic                div_done;
  logic [FIELD_W-1:0]  div_rem;

  assign ld_idx = in_data[IDX_IN_W-1:0];
  assign ld_ok = 32'(ld_idx) < NUM_TASKS;

  assign cur_st = st_tab[idx];
  assign cur_dl = dl_tab[idx];
  assign cur_rp = rp_tab[idx];
  assign cur_wr = wr_tab[idx];
  assign cur_wl = work_left[idx];

  assign x = time_now - {{(TIME_W-FIELD_W){1'b0}}, cur_st};
  assign active = cur_dl != '0 && cur_rp != '0
                  && time_now >= {{(TIME_W-FIELD_W){1'b0}}, cur_st};

  assign inc_d = {1'b0, ph_d[idx]} + 1'b1;
  assign inc_p = {1'b0, ph_p[idx]} + 1'b1;
  assign fast_d = (x == '0 || inc_d == {1'b0, cur_dl}) ? '0 : inc_d[FIELD_W-1:0];
  assign fast_p = (x == '0 || inc_p == {1'b0, cur_rp}) ? '0 : inc_p[FIELD_W-1:0];
  assign pd = cmd.use_div ? rem_d : fast_d;
  assign pp = cmd.use_div ? rem_p : fast_p;

  assign miss = pd == '0 && cur_wl != '0;
  assign rel = pp == '0;
  assign sum_w = {1'b0, cur_wl} + {1'b0, cur_wr};
  assign wnew = !rel ? cur_wl : (sum_w[FIELD_W] ? '1 : sum_w[FIELD_W-1:0]);
  assign lax = $signed({2'b00, cur_dl}) - LAX_W'(1) - $signed({2'b00, pd})
               - $signed({2'b00, wnew});
  assign cand = active && wnew != '0;
  assign in_mask = 32'(idx) < MASK_W;

  assign status.need_div = active && !synced[idx] && x != '0;
  assign status.last_idx = 32'(idx) == NUM_TASKS - 1;
  assign status.div_done = div_done;
  assign status.out_free = !out_valid || out_ready;

  llts_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (x),
    .divisor   (cmd.div_sel_p ? cur_rp : cur_dl),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      time_now <= '0;
      synced <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_TASKS; i++) begin
        st_tab[i] <= '0;
        dl_tab[i] <= '0;
        rp_tab[i] <= '0;
        wr_tab[i] <= '0;
        work_left[i] <= '0;
      end
    end else begin
      if (cmd.load && ld_ok) begin
        st_tab[IW'(ld_idx)] <= in_data[IDX_IN_W +: FIELD_W];
        dl_tab[IW'(ld_idx)] <= in_data[IDX_IN_W+FIELD_W +: FIELD_W];
        rp_tab[IW'(ld_idx)] <= in_data[IDX_IN_W+2*FIELD_W +: FIELD_W];
        wr_tab[IW'(ld_idx)] <= in_data[IDX_IN_W+3*FIELD_W +: FIELD_W];
        work_left[IW'(ld_idx)] <= '0;
        synced[IW'(ld_idx)] <= 1'b0;
      end
      if (cmd.apply) begin
        if (active) begin
          work_left[idx] <= wnew;
          synced[idx] <= 1'b1;
        end else begin
          synced[idx] <= 1'b0;
        end
      end
      if (cmd.finish) begin
        time_now <= time_now + 1'b1;
        if (found) work_left[best] <= work_left[best] - 1'b1;
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_d) rem_d <= div_rem;
    if (cmd.latch_p) rem_p <= div_rem;
    if (cmd.tick_init) begin
      idx <= '0;
      found <= 1'b0;
      best <= '0;
      best_lax <= '0;
      missed <= '0;
      released <= '0;
    end
    if (cmd.step && !status.last_idx) idx <= idx + 1'b1;
    if (cmd.apply && active) begin
      ph_d[idx] <= pd;
      ph_p[idx] <= pp;
      if (in_mask && miss) missed[IDX_IN_W'(idx)] <= 1'b1;
      if (in_mask && rel) released[IDX_IN_W'(idx)] <= 1'b1;
      if (cand && (!found || lax < best_lax)) begin
        found <= 1'b1;
        best <= idx;
        best_lax <= lax;
      end
    end
    if (cmd.finish) begin
      out_chosen <= found;
      out_data <= {{(OUT_DATA_W-IDX_IN_W-2*MASK_W){1'b0}}, released, missed,
                   found ? IDX_IN_W'(best) : IDX_IN_W'(0)};
    end
  end

endmodule

/* design/least_laxity_task_scheduler.sv */
// Top level of the least-laxity task scheduler: controller plus datapath.
// Depends on llts_pkg, llts_ctrl, llts_dp and llts_div.
//
// A load item gives no result. A tick item walks the task entries one per cycle
// while every active task's phase is tracked from the previous tick; a task seen
// for the first time after a load, or after a gap before its start, needs two
// 32-step remainder computations, which hold the walk at that task. Each tick
// gives one result item; a new item is taken once the result is registered.
module least_laxity_task_scheduler
  import llts_pkg::*;
#(
  parameter int unsigned NUM_TASKS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // task_index[2:0], start_time[18:3], deadline_period[34:19],
  // release_period[50:35], work_per_release[66:51], zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // command
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // chosen_task[2:0], missed_mask[10:3], released_mask[18:11], zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // task_chosen
  output logic                  m_axis_tuser
);

  llts_cmd_t    cmd;
  llts_status_t status;

  llts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_cmd   (s_axis_tuser),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  llts_dp #(
    .NUM_TASKS (NUM_TASKS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .in_data    (s_axis_tdata),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_chosen (m_axis_tuser),
    .out_data   (m_axis_tdata)
  );

endmodule

/* sim/tb_least_laxity_task_scheduler.sv */
// Self-checking testbench for the least-laxity task scheduler top level.
// Loads task entries and advances ticks, predicting each tick's schedule result.
// Depends on llts_pkg and least_laxity_task_scheduler.
`timescale 1ns / 100ps

module tb_least_laxity_task_scheduler;
  import llts_pkg::*;

  localparam int NTASK = 8;
  localparam int WATCHDOG_LIMIT = 200000;

  typedef struct packed {
    logic        command;
    logic [2:0]  task_index;
    logic [15:0] start_time;
    logic [15:0] deadline_period;
    logic [15:0] release_period;
    logic [15:0] work_per_release;
  } sched_item_t;

  typedef struct packed {
    logic [2:0] chosen_task;
    logic       task_chosen;
    logic [7:0] missed_mask;
    logic [7:0] released_mask;
  } sched_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;

  least_laxity_task_scheduler #(.NUM_TASKS(NTASK)) uut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  sched_item_t pending_items[$];
  sched_result_t expected_schedule[$];
  logic [31:0] sched_time;
  logic [15:0] task_start[NTASK], task_dl[NTASK], task_rp[NTASK], task_work[NTASK];
  logic [15:0] work_left[NTASK];
  int errors = 0;
  bit stimulus_done = 0;
  int idle_cycles = 0;
  int burst_left = 0, gap_left = 0;
  int stall_phase = 0;

  function automatic void predict_item(sched_item_t it);
    sched_result_t r;
    logic [31:0] x, ph[NTASK];
    bit act[NTASK];
    longint lax, best_lax;
    int unsigned s;
    if (it.command == CMD_LOAD) begin
      task_start[it.task_index] = it.start_time;
      task_dl[it.task_index] = it.deadline_period;
      task_rp[it.task_index] = it.release_period;
      task_work[it.task_index] = it.work_per_release;
      work_left[it.task_index] = '0;
      return;
    end
    r = '0;
    best_lax = 0;
    for (int i = 0; i < NTASK; i++) begin
      act[i] = 0;
      ph[i] = 0;
      if (task_dl[i] == 0 || task_rp[i] == 0 || sched_time < task_start[i]) continue;
      act[i] = 1;
      x = sched_time - task_start[i];
      ph[i] = x % task_dl[i];
      if (ph[i] == 0 && work_left[i] != 0) r.missed_mask[i] = 1'b1;
      if (x % task_rp[i] == 0) begin
        s = work_left[i] + task_work[i];
        work_left[i] = (s > 65535) ? 16'hFFFF : s[15:0];
        r.released_mask[i] = 1'b1;
      end
    end
    for (int i = 0; i < NTASK; i++) begin
      if (!act[i] || work_left[i] == 0) continue;
      lax = longint'(task_dl[i]) - 1 - longint'(ph[i]) - longint'(work_left[i]);
      if (!r.task_chosen || lax < best_lax) begin
        r.task_chosen = 1'b1;
        r.chosen_task = i[2:0];
        best_lax = lax;
      end
    end
    if (r.task_chosen) work_left[r.chosen_task] = work_left[r.chosen_task] - 1'b1;
    sched_time = sched_time + 1;
    expected_schedule = {expected_schedule, r};
  endfunction

  function automatic sched_item_t make_load(int idx, int st, int dl, int rp, int w);
    sched_item_t it;
    it.command = CMD_LOAD;
    it.task_index = idx[2:0];
    it.start_time = st[15:0];
    it.deadline_period = dl[15:0];
    it.release_period = rp[15:0];
    it.work_per_release = w[15:0];
    return it;
  endfunction

  function automatic sched_item_t make_tick();
    sched_item_t it;
    it = sched_item_t'($urandom) ^ {1'b0, 71'($urandom)};
    it.command = CMD_TICK;
    return it;
  endfunction

  function automatic sched_item_t random_load();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0)
      return make_load($urandom_range(0, 7), $urandom_range(0, 65535), $urandom_range(0, 65535),
                       $urandom_range(0, 65535), $urandom_range(0, 65535));
    if (sel == 1)
      return make_load($urandom_range(0, 7), $urandom_range(0, 40), $urandom_range(0, 2),
                       $urandom_range(0, 2), $urandom_range(60000, 65535));
    return make_load($urandom_range(0, 7), $urandom_range(0, 60), $urandom_range(1, 12),
                     $urandom_range(1, 12), $urandom_range(0, 5));
  endfunction

  task automatic it_drive(sched_item_t it);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= it.command;
    s_axis_tdata <= {5'b0, it.work_per_release, it.release_period, it.deadline_period,
                     it.start_time, it.task_index};
  endtask

  initial begin
    sched_item_t it;
    sched_time = 0;
    for (int i = 0; i < NTASK; i++) begin
      task_start[i] = 0; task_dl[i] = 0; task_rp[i] = 0; task_work[i] = 0; work_left[i] = 0;
    end
    // Directed part: idle ticks, disabled and late-start tasks, saturation, ties.
    pending_items = {pending_items, make_tick()};
    pending_items = {pending_items, make_load(0, 0, 4, 4, 2)};
    pending_items = {pending_items, make_load(1, 0, 4, 4, 2)};
    pending_items = {pending_items, make_load(2, 0, 0, 3, 1)};
    pending_items = {pending_items, make_load(3, 0, 3, 0, 1)};
    pending_items = {pending_items, make_load(4, 6, 2, 1, 65535)};
    pending_items = {pending_items, make_load(5, 0, 1, 1, 65535)};
    pending_items = {pending_items, make_load(6, 65535, 65535, 65535, 65535)};
    pending_items = {pending_items, make_load(7, 0, 5, 2, 3)};
    repeat (10) pending_items = {pending_items, make_tick()};
    pending_items = {pending_items, make_load(5, 0, 0, 0, 0)};
    pending_items = {pending_items, make_load(4, 0, 0, 0, 0)};
    repeat (4) pending_items = {pending_items, make_tick()};
    for (int n = 0; n < 2000; n++) begin
      it = ($urandom_range(0, 3) == 0) ? random_load() : make_tick();
      pending_items = {pending_items, it};
    end
    stimulus_done = 1;
  end

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid)
        predict_item(sched_item_t'({s_axis_tuser, s_axis_tdata[2:0], s_axis_tdata[18:3],
                                    s_axis_tdata[34:19], s_axis_tdata[50:35],
                                    s_axis_tdata[66:51]}));
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        it_drive(pending_items.pop_front());
        if (burst_left == 0) begin
          burst_left <= $urandom_range(0, 20);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stalls follow a rotating pattern with open stretches.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      stall_phase <= (stall_phase + 1) % 600;
      if (stall_phase < 200) m_axis_tready <= 1'b1;
      else if (stall_phase < 400) m_axis_tready <= ($urandom_range(0, 1) == 1);
      else m_axis_tready <= ($urandom_range(0, 7) == 0);
    end
  end

  always @(posedge clk) begin
    sched_result_t got, exp_r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.chosen_task = m_axis_tdata[2:0];
      got.missed_mask = m_axis_tdata[10:3];
      got.released_mask = m_axis_tdata[18:11];
      got.task_chosen = m_axis_tuser;
      if (expected_schedule.size() == 0) begin
        $error("unexpected result item %h", got);
        errors++;
      end else begin
        exp_r = expected_schedule.pop_front();
        if (got.chosen_task !== exp_r.chosen_task) begin
          $error("chosen_task expected %0d actual %0d", exp_r.chosen_task, got.chosen_task);
          errors++;
        end
        if (got.task_chosen !== exp_r.task_chosen) begin
          $error("task_chosen expected %0d actual %0d", exp_r.task_chosen, got.task_chosen);
          errors++;
        end
        if (got.missed_mask !== exp_r.missed_mask) begin
          $error("missed_mask expected %h actual %h", exp_r.missed_mask, got.missed_mask);
          errors++;
        end
        if (got.released_mask !== exp_r.released_mask) begin
          $error("released_mask expected %h actual %h", exp_r.released_mask,
                 got.released_mask);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    wait (stimulus_done);
    wait (pending_items.size() == 0 && !s_axis_tvalid);
    @(posedge clk);
    wait (expected_schedule.size() == 0);
    repeat (1000) @(posedge clk);
    if (errors == 0 && expected_schedule.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

/* least_laxity_task_scheduler.f */
design/llts_pkg.sv
design/llts_div.sv
design/llts_ctrl.sv
design/llts_dp.sv
design/least_laxity_task_scheduler.sv
sim/tb_least_laxity_task_scheduler.sv
